>>> rtl/core/asdm_pkg.sv
// ---------------------------------------------------------------------------
// asdm_pkg
// Shared widths, state encoding and request types of the agent set distance
// metrics unit.
// ---------------------------------------------------------------------------
package asdm_pkg;

    localparam int MAX_AGENTS = 256;
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;

    localparam int CNT_W   = $clog2(MAX_AGENTS + 1);
    localparam int ADDR_W  = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int ROOT_STEPS = (SQ_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_STEPS;
    localparam int DIST_W  = ROOT_STEPS;
    localparam int WORST_W = DIST_W - FRAC_BITS;
    localparam int DSUM_W  = 27;
    localparam int SQS_W   = 30;
    localparam int DIVD_W  = DSUM_W;
    localparam int DIVS_W  = CNT_W;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SQR   = 10'b0000000010,
        ST_RGO   = 10'b0000000100,
        ST_ROOT  = 10'b0000001000,
        ST_ACC   = 10'b0000010000,
        ST_CHK   = 10'b0000100000,
        ST_MEAN  = 10'b0001000000,
        ST_SCAN  = 10'b0010000000,
        ST_BGO   = 10'b0100000000,
        ST_BWAIT = 10'b1000000000
    } state_t;

endpackage

>>> rtl/core/asdm_sqrt.sv
// ---------------------------------------------------------------------------
// asdm_sqrt
// Restoring bit-serial square root giving a fixed-point distance, one root
// bit per cycle.
// ---------------------------------------------------------------------------
module asdm_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [asdm_pkg::SQ_W-1:0]  sq,
    output logic                       done,
    output logic [asdm_pkg::DIST_W-1:0] root_val
);
    import asdm_pkg::*;

    localparam int STEP_W = $clog2(ROOT_STEPS + 1);
    localparam int REM_W  = DIST_W + 3;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIST_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [REM_W-1:0]  rem_sh, trial;

    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = RAD_W'(sq) << (2 * FRAC_BITS);
            rem_next  = '0;
            root_next = '0;
            step_next = STEP_W'(ROOT_STEPS);
        end
        else if (step_reg != '0)
        begin
            rad_next  = rad_reg << 2;
            step_next = step_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[DIST_W-2:0], 1'b0};
            end
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done     = done_reg;
    assign root_val = root_reg;
endmodule

>>> rtl/core/asdm_div.sv
// ---------------------------------------------------------------------------
// asdm_div
// Restoring truncating divider, one quotient bit per cycle, shared by the
// overall mean and the selected mean.
// ---------------------------------------------------------------------------
module asdm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  asdm_pkg::div_req_t req,
    output asdm_pkg::div_rsp_t rsp
);
    import asdm_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] q_reg, q_next;
    logic [DIVS_W:0]   rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg[DIVS_W-1:0], q_reg[DIVD_W-1]};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = STEP_W'(DIVD_W);
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DIVD_W-2:0], 1'b0};
            end
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;
endmodule

>>> rtl/core/asdm_store.sv
// ---------------------------------------------------------------------------
// asdm_store
// Distance store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module asdm_store (
    input  logic                         clk,
    input  logic                         we,
    input  logic [asdm_pkg::ADDR_W-1:0]  waddr,
    input  logic [asdm_pkg::DIST_W-1:0]  wdata,
    input  logic                         re,
    input  logic [asdm_pkg::ADDR_W-1:0]  raddr,
    output logic [asdm_pkg::DIST_W-1:0]  rdata
);
    import asdm_pkg::*;

    logic [DIST_W-1:0] mem [MAX_AGENTS];
    logic [DIST_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/agent_set_distance_metrics_unit.sv
// ---------------------------------------------------------------------------
// agent_set_distance_metrics_unit
// Distance metrics between the start points of two agent sets.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request carries
// one agent. Every agent is squared, then rooted by the bit-serial square
// root, then accumulated. The request that carries last_agent adds a closing
// pass: a division for the overall mean, a scan of the distance store at one
// entry per cycle, a launch state and a second division for the selected
// mean. The single result is shown in the cycle after the closing pass for
// exactly one cycle with result_valid high and must be captured then, since
// the receiver cannot stall the block. An empty set reports zeros, and agents
// beyond the store depth are dropped while last_agent still closes the set.
// ---------------------------------------------------------------------------
module agent_set_distance_metrics_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [asdm_pkg::COORD_BITS-1:0] stored_x,
    input  logic [asdm_pkg::COORD_BITS-1:0] stored_y,
    input  logic [asdm_pkg::COORD_BITS-1:0] new_x,
    input  logic [asdm_pkg::COORD_BITS-1:0] new_y,
    input  logic                            last_agent,
    output logic                            result_valid,
    output logic [26:0]                     distance_sum,
    output logic [28:0]                     squared_sum,
    output logic [10:0]                     worst_distance,
    output logic [18:0]                     better_mean,
    output logic [8:0]                      agents_seen
);
    import asdm_pkg::*;

    state_t state_reg, state_next;

    // Per-request working registers.
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic                  last_reg;
    logic [DIST_W-1:0]     dist_reg;

    // Accumulated state of the open set.
    logic [CNT_W-1:0]   count_reg;
    logic [DSUM_W-1:0]  dsum_reg;
    logic [SQS_W-1:0]   sqs_reg;
    logic [WORST_W-1:0] worst_reg;

    // Closing pass.
    logic [DIVD_W-1:0] mean_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              rd_vld_reg;
    logic [DSUM_W-1:0] bsum_reg;
    logic [CNT_W-1:0]  bcnt_reg;

    // Result registers.
    logic        res_vld_reg;
    logic [26:0] res_dsum_reg;
    logic [28:0] res_sqs_reg;
    logic [10:0] res_worst_reg;
    logic [18:0] res_better_reg;
    logic [8:0]  res_cnt_reg;

    logic              root_start, root_done;
    logic [DIST_W-1:0] root_dist;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic              st_we, st_re;
    logic [DIST_W-1:0] st_rdata;
    logic              accept, room, issue, emit;

    assign accept = start && (state_reg == ST_IDLE);
    assign room   = (count_reg < CNT_W'(MAX_AGENTS));
    assign issue  = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign st_we  = (state_reg == ST_ACC) && room;
    assign st_re  = issue;

    assign root_start = (state_reg == ST_RGO);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = dsum_reg;
        div_req.divisor  = count_reg;
        if ((state_reg == ST_CHK) && last_reg && (count_reg != '0))
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == ST_BGO)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = bsum_reg;
            div_req.divisor  = bcnt_reg;
        end
    end

    // A result is due when a closing set is empty or the second division ends.
    assign emit = ((state_reg == ST_CHK) && last_reg && (count_reg == '0))
               || ((state_reg == ST_BWAIT) && div_rsp.done);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SQR;
            ST_SQR:   state_next = ST_RGO;
            ST_RGO:   state_next = ST_ROOT;
            ST_ROOT:  if (root_done) state_next = ST_ACC;
            ST_ACC:   state_next = ST_CHK;
            ST_CHK:
            begin
                if (!last_reg || (count_reg == '0))
                    state_next = ST_IDLE;
                else
                    state_next = ST_MEAN;
            end
            ST_MEAN:  if (div_rsp.done) state_next = ST_SCAN;
            ST_SCAN:  if (!issue && !rd_vld_reg) state_next = ST_BGO;
            ST_BGO:   state_next = ST_BWAIT;
            ST_BWAIT: if (div_rsp.done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            dsum_reg     <= '0;
            sqs_reg      <= '0;
            worst_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            bsum_reg     <= '0;
            bcnt_reg     <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_vld_reg <= emit;
            rd_vld_reg  <= issue;
            if (st_we)
            begin
                count_reg <= count_reg + 1'b1;
                dsum_reg  <= dsum_reg + DSUM_W'(dist_reg);
                sqs_reg   <= sqs_reg + SQS_W'(sq_reg);
                if (dist_reg[DIST_W-1 -: WORST_W] > worst_reg)
                    worst_reg <= dist_reg[DIST_W-1 -: WORST_W];
            end
            if ((state_reg == ST_MEAN) && div_rsp.done)
            begin
                scan_idx_reg <= '0;
                bsum_reg     <= '0;
                bcnt_reg     <= '0;
            end
            if (issue)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            // Stored data arrives in the cycle after its read address.
            if (rd_vld_reg && (DIVD_W'(st_rdata) <= mean_reg))
            begin
                bsum_reg <= bsum_reg + DSUM_W'(st_rdata);
                bcnt_reg <= bcnt_reg + 1'b1;
            end
            if (emit)
            begin
                count_reg <= '0;
                dsum_reg  <= '0;
                sqs_reg   <= '0;
                worst_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg   <= (stored_x > new_x) ? stored_x - new_x : new_x - stored_x;
            dy_reg   <= (stored_y > new_y) ? stored_y - new_y : new_y - stored_y;
            last_reg <= last_agent;
        end
        if (state_reg == ST_SQR)
            sq_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg) + SQ_W'(dy_reg) * SQ_W'(dy_reg);
        if (root_done)
            dist_reg <= root_dist;
        if ((state_reg == ST_MEAN) && div_rsp.done)
            mean_reg <= div_rsp.quotient;
        if (emit)
        begin
            res_dsum_reg  <= 27'(dsum_reg);
            res_sqs_reg   <= 29'(sqs_reg);
            res_worst_reg <= 11'(worst_reg);
            res_cnt_reg   <= 9'(count_reg);
            if ((state_reg == ST_BWAIT) && (bcnt_reg != '0))
                res_better_reg <= 19'(div_rsp.quotient);
            else
                res_better_reg <= '0;
        end
    end

    asdm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .sq       (sq_reg),
        .done     (root_done),
        .root_val (root_dist)
    );

    asdm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    asdm_store u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (dist_reg),
        .re    (st_re),
        .raddr (scan_idx_reg[ADDR_W-1:0]),
        .rdata (st_rdata)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = res_vld_reg;
    assign distance_sum   = res_dsum_reg;
    assign squared_sum    = res_sqs_reg;
    assign worst_distance = res_worst_reg;
    assign better_mean    = res_better_reg;
    assign agents_seen    = res_cnt_reg;

    // The set never holds more agents than the store has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_AGENTS))
        else $error("agent count beyond store depth");

    // The scan selects no more entries than it has scanned.
    a_bcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= scan_idx_reg)
        else $error("selected count exceeds scanned entries");

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request accepted without going busy");

    // A result leaves the set cleared and the block idle.
    a_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && (count_reg == '0)))
        else $error("result shown while set still open");

endmodule
